[rtl/core/stbl_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the bracket lookup core.
package stbl_pkg;

  localparam int MAX_LEVELS  = 8;
  localparam int LEVEL_WORDS = 1024;
  localparam int LEAF_WORDS  = 4096;
  localparam int NODE_KEYS   = 8;
  localparam int KEY_WIDTH   = 64;

  localparam int OP_W    = 2;
  localparam int LEVEL_W = 3;
  localparam int WIDX_W  = 12;
  localparam int WORD_W  = 64;
  localparam int QUERY_W = 64;
  localparam int VALUE_W = 64;
  localparam int LC_W    = 4;

  localparam int IN_TDATA_W  = ((LEVEL_W + WIDX_W + WORD_W + QUERY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * VALUE_W + 7) / 8) * 8;

  localparam int INT_DEPTH = MAX_LEVELS * LEVEL_WORDS;
  localparam int INT_AW    = $clog2(INT_DEPTH);
  localparam int LVL_AW    = $clog2(LEVEL_WORDS);
  localparam int LEAF_AW   = $clog2(LEAF_WORDS);
  localparam int CNT_W     = $clog2(NODE_KEYS + 1);
  localparam int OFF_W     = $clog2(3 * NODE_KEYS + 1);
  localparam int INT_SW    = ((LVL_AW > OFF_W) ? LVL_AW : OFF_W) + 1;
  localparam int LEAF_SW   = ((LEAF_AW > OFF_W) ? LEAF_AW : OFF_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP  = 2'd0,
    OP_WR_INT  = 2'd1,
    OP_WR_LEAF = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    RD_INT  = 2'd0,
    RD_LEAF = 2'd1,
    RD_PREV = 2'd2
  } rd_kind_t;

  typedef struct packed {
    logic             start;
    logic             rd;
    rd_kind_t         kind;
    logic             bracket;
    logic [LC_W-1:0]  level;
    logic [OFF_W-1:0] off;
    logic             node_load;
    logic             lo_load;
    logic             hi_load;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic gt;
    logic ge;
    logic out_busy;
  } dp_stat_t;

endpackage

[rtl/core/stbl_dp.sv]
// Datapath: page and leaf stores, node pointer, key compare, bracket and output registers.
module stbl_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  stbl_pkg::dp_cmd_t                 cmd,
  input  logic [stbl_pkg::OP_W-1:0]         op,
  input  logic [stbl_pkg::LEVEL_W-1:0]      level,
  input  logic [stbl_pkg::WIDX_W-1:0]       word_index,
  input  logic [stbl_pkg::WORD_W-1:0]       word_data,
  input  logic [stbl_pkg::QUERY_W-1:0]      query,
  output stbl_pkg::dp_stat_t                stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [stbl_pkg::VALUE_W-1:0]      lower_value,
  output logic [stbl_pkg::VALUE_W-1:0]      upper_value,
  output logic                              beyond_edge
);
  import stbl_pkg::*;

  logic [KEY_WIDTH-1:0] int_mem [INT_DEPTH];
  logic [KEY_WIDTH-1:0] leaf_mem [LEAF_WORDS];

  logic [KEY_WIDTH-1:0] query_q;
  logic [KEY_WIDTH-1:0] node;
  logic [KEY_WIDTH-1:0] int_q;
  logic [KEY_WIDTH-1:0] leaf_q;
  logic                 rd_sel_leaf;
  logic                 rd_zero;
  logic [KEY_WIDTH-1:0] lo;
  logic [KEY_WIDTH-1:0] hi;
  logic                 edge_acc;
  logic [KEY_WIDTH-1:0] out_lo;
  logic [KEY_WIDTH-1:0] out_hi;
  logic                 out_edge;

  logic                 int_we;
  logic [INT_AW-1:0]    int_waddr;
  logic                 leaf_we;
  logic [INT_SW-1:0]    int_sum;
  logic                 int_ok;
  logic [INT_AW-1:0]    int_raddr;
  logic                 int_re;
  logic [LEAF_SW-1:0]   leaf_sum;
  logic                 leaf_ok;
  logic [KEY_WIDTH-1:0] node_m1;
  logic                 prev_ok;
  logic [LEAF_AW-1:0]   leaf_raddr;
  logic                 leaf_rok;
  logic                 leaf_re;
  logic                 rd_ok;
  logic [KEY_WIDTH-1:0] rdata;

  assign int_we    = cmd.start && (op == OP_WR_INT) && (32'(level) < MAX_LEVELS)
                     && (32'(word_index) < LEVEL_WORDS);
  assign int_waddr = INT_AW'(level) * INT_AW'(LEVEL_WORDS) + INT_AW'(word_index);
  assign leaf_we   = cmd.start && (op == OP_WR_LEAF) && (32'(word_index) < LEAF_WORDS);

  assign int_sum   = INT_SW'(node[LVL_AW-1:0]) + INT_SW'(cmd.off);
  assign int_ok    = (node < KEY_WIDTH'(LEVEL_WORDS)) && (int_sum < INT_SW'(LEVEL_WORDS));
  assign int_raddr = INT_AW'(cmd.level) * INT_AW'(LEVEL_WORDS) + INT_AW'(int_sum);

  assign leaf_sum  = LEAF_SW'(node[LEAF_AW-1:0]) + LEAF_SW'(cmd.off);
  assign leaf_ok   = (node < KEY_WIDTH'(LEAF_WORDS)) && (leaf_sum < LEAF_SW'(LEAF_WORDS));
  assign node_m1   = node - KEY_WIDTH'(1);
  assign prev_ok   = (node != '0) && (node_m1 < KEY_WIDTH'(LEAF_WORDS));

  always_comb begin
    if (cmd.kind == RD_PREV) begin
      leaf_raddr = node_m1[LEAF_AW-1:0];
      leaf_rok   = prev_ok;
    end else begin
      leaf_raddr = leaf_sum[LEAF_AW-1:0];
      leaf_rok   = leaf_ok;
    end
  end

  assign rd_ok   = (cmd.kind == RD_INT) ? int_ok : leaf_rok;
  assign int_re  = cmd.rd && (cmd.kind == RD_INT) && int_ok;
  assign leaf_re = cmd.rd && (cmd.kind != RD_INT) && leaf_rok;

  always_ff @(posedge clk) begin
    if (int_we) begin
      int_mem[int_waddr] <= word_data[KEY_WIDTH-1:0];
    end
    if (int_re) begin
      int_q <= int_mem[int_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[word_index[LEAF_AW-1:0]] <= word_data[KEY_WIDTH-1:0];
    end
    if (leaf_re) begin
      leaf_q <= leaf_mem[leaf_raddr];
    end
  end

  // out-of-range reads return zero
  assign rdata = rd_zero ? '0 : (rd_sel_leaf ? leaf_q : int_q);

  assign stat.gt       = query_q > rdata;
  assign stat.ge       = query_q >= rdata;
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      query_q  <= query[KEY_WIDTH-1:0];
      node     <= '0;
      edge_acc <= 1'b0;
    end else begin
      if (cmd.node_load) begin
        node <= rdata;
      end
      if (cmd.rd && cmd.bracket && !rd_ok) begin
        edge_acc <= 1'b1;
      end
    end
    if (cmd.rd) begin
      rd_sel_leaf <= (cmd.kind != RD_INT);
      rd_zero     <= !rd_ok;
    end
    if (cmd.lo_load) begin
      lo <= rdata;
    end
    if (cmd.hi_load) begin
      hi <= rdata;
    end
    if (cmd.out_load) begin
      out_lo   <= lo;
      out_hi   <= hi;
      out_edge <= edge_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign lower_value = VALUE_W'(out_lo);
  assign upper_value = VALUE_W'(out_hi);
  assign beyond_edge = out_edge;

endmodule

[rtl/core/stbl_ctrl.sv]
// Controller: level walk, key scan, leaf scan and bracket read sequencing.
module stbl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [stbl_pkg::OP_W-1:0]     op,
  input  logic                          cfg_we,
  input  logic [stbl_pkg::LC_W-1:0]     cfg_wdata,
  input  stbl_pkg::dp_stat_t            stat,
  output stbl_pkg::dp_cmd_t             cmd
);
  import stbl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KEY_RD,
    S_KEY_EV,
    S_CHILD_RD,
    S_CHILD_EV,
    S_LEAF_RD,
    S_LEAF_EV,
    S_LO_RD,
    S_HI_RD,
    S_HI_EV,
    S_DONE
  } state_t;

  state_t           state;
  logic [LC_W-1:0]  level_count;
  logic [LC_W-1:0]  k;
  logic [CNT_W-1:0] cnt;
  logic [LC_W-1:0]  levels;
  logic             accept;

  assign levels   = (32'(level_count) > MAX_LEVELS) ? LC_W'(MAX_LEVELS) : level_count;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    cmd.start = accept;
    cmd.level = k;
    unique case (state)
      S_KEY_RD: begin
        cmd.rd   = 1'b1;
        cmd.kind = RD_INT;
        cmd.off  = OFF_W'(cnt);
      end
      S_CHILD_RD: begin
        cmd.rd   = 1'b1;
        cmd.kind = RD_INT;
        cmd.off  = OFF_W'(NODE_KEYS) + OFF_W'(cnt);
      end
      S_CHILD_EV: begin
        cmd.node_load = 1'b1;
      end
      S_LEAF_RD: begin
        cmd.rd   = 1'b1;
        cmd.kind = RD_LEAF;
        cmd.off  = OFF_W'(cnt);
      end
      S_LO_RD: begin
        cmd.rd      = 1'b1;
        cmd.bracket = 1'b1;
        if (cnt == '0) begin
          cmd.kind = RD_PREV;
        end else begin
          cmd.kind = RD_LEAF;
          cmd.off  = OFF_W'(NODE_KEYS - 1) + OFF_W'(cnt);
        end
      end
      S_HI_RD: begin
        cmd.lo_load = 1'b1;
        cmd.rd      = 1'b1;
        cmd.bracket = 1'b1;
        cmd.kind    = RD_LEAF;
        if (cnt == CNT_W'(NODE_KEYS)) begin
          cmd.off = OFF_W'(3 * NODE_KEYS);
        end else begin
          cmd.off = OFF_W'(NODE_KEYS) + OFF_W'(cnt);
        end
      end
      S_HI_EV: begin
        cmd.hi_load = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      level_count <= '0;
      k           <= '0;
      cnt         <= '0;
    end else begin
      if (cfg_we) begin
        level_count <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (op == OP_LOOKUP)) begin
            k     <= '0;
            cnt   <= '0;
            state <= (levels == '0) ? S_LEAF_RD : S_KEY_RD;
          end
        end
        S_KEY_RD: begin
          state <= S_KEY_EV;
        end
        S_KEY_EV: begin
          if (stat.gt) begin
            cnt   <= cnt + CNT_W'(1);
            state <= (cnt == CNT_W'(NODE_KEYS - 1)) ? S_CHILD_RD : S_KEY_RD;
          end else begin
            state <= S_CHILD_RD;
          end
        end
        S_CHILD_RD: begin
          state <= S_CHILD_EV;
        end
        S_CHILD_EV: begin
          cnt <= '0;
          if (k + LC_W'(1) == levels) begin
            state <= S_LEAF_RD;
          end else begin
            k     <= k + LC_W'(1);
            state <= S_KEY_RD;
          end
        end
        S_LEAF_RD: begin
          state <= S_LEAF_EV;
        end
        S_LEAF_EV: begin
          if (stat.ge) begin
            cnt   <= cnt + CNT_W'(1);
            state <= (cnt == CNT_W'(NODE_KEYS - 1)) ? S_LO_RD : S_LEAF_RD;
          end else begin
            state <= S_LO_RD;
          end
        end
        S_LO_RD: begin
          state <= S_HI_RD;
        end
        S_HI_RD: begin
          state <= S_HI_EV;
        end
        S_HI_EV: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(NODE_KEYS))
    else $error("key count exceeds node size");

  a_lookup_starts: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_LOOKUP) |=> state != S_IDLE)
    else $error("lookup transaction did not start a walk");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.rd && (cmd.kind == RD_INT) |-> (k < levels))
    else $error("internal read beyond walked levels");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_busy)
    else $error("result loaded over a pending transaction");

endmodule

[rtl/core/static_tree_bracket_lookup_core.sv]
// Top level of the static search tree bracket lookup core.
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | write or lookup transaction, op in tuser
//  m_axis   | out       | bracket values, beyond_edge in tuser
//  cfg      | in        | level_count register write
//
// A write leaves the controller idle; the core is ready again the next cycle.
// A lookup walks the levels (key scan, then child pointer read), scans the leaf
// keys, then reads the lower and upper bracket; each read step is one
// synchronous read of a page or leaf store.
// rst is synchronous and clears the controller, level_count and output valid.
// A stalled m_axis holds its result; the next lookup waits in its last cycle for it.
module static_tree_bracket_lookup_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // level, word_index, word_data, query (from bit 0), zero padded
  input  logic [stbl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // op
  input  logic [stbl_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // lower_value, upper_value (from bit 0)
  output logic [stbl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // beyond_edge
  output logic                                m_axis_tuser,
  input  logic                                cfg_we,
  input  logic [stbl_pkg::LC_W-1:0]           cfg_wdata
);
  import stbl_pkg::*;

  localparam int LEVEL_LSB = 0;
  localparam int WIDX_LSB  = LEVEL_LSB + LEVEL_W;
  localparam int WORD_LSB  = WIDX_LSB + WIDX_W;
  localparam int QUERY_LSB = WORD_LSB + WORD_W;

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [LEVEL_W-1:0]  level;
  logic [WIDX_W-1:0]   word_index;
  logic [WORD_W-1:0]   word_data;
  logic [QUERY_W-1:0]  query;
  logic [VALUE_W-1:0]  lower_value;
  logic [VALUE_W-1:0]  upper_value;

  assign level      = s_axis_tdata[LEVEL_LSB +: LEVEL_W];
  assign word_index = s_axis_tdata[WIDX_LSB +: WIDX_W];
  assign word_data  = s_axis_tdata[WORD_LSB +: WORD_W];
  assign query      = s_axis_tdata[QUERY_LSB +: QUERY_W];

  assign m_axis_tdata = OUT_TDATA_W'({upper_value, lower_value});

  stbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .op        (s_axis_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd)
  );

  stbl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (s_axis_tuser),
    .level       (level),
    .word_index  (word_index),
    .word_data   (word_data),
    .query       (query),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .lower_value (lower_value),
    .upper_value (upper_value),
    .beyond_edge (m_axis_tuser)
  );

endmodule
